// File: hdl/esp_pkg.sv
// Shared constants and types for the escape stuffer packetizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package esp_pkg;

    // Transfer size in bytes, and the width of the fill counter.
    localparam int PACKET_BYTES = 64;
    localparam int CNT_W        = 6;

    localparam logic [7:0] ESCAPE_RESET = 8'h1b;
    localparam logic [7:0] END_RESET    = 8'h04;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ESCAPE = 1'b0;
    localparam logic REG_END    = 1'b1;

    localparam int ADDR_W = 3;

    // Input word kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] escape_code;
        logic [7:0] end_code;
    } cfg_t;

endpackage

`default_nettype wire

// File: hdl/escape_stuffer_packetizer_unit.sv
// Escape byte stuffer with transfer packetizer, top level.
// A word accepted into the input register passes on to the output register.
// Throughput: one input word per cycle while m_ready is high; a word that needs
// escaping emits two bytes and holds the next word back, as the single output
// register emits one byte per cycle.
// Reset (aresetn, synchronous, active low) empties all stages, clears the fill
// counter and loads the escape and end codes with 0x1b and 0x04.
`default_nettype none

module escape_stuffer_packetizer_unit import esp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_kind,
    input  wire logic [7:0]        s_data_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_packet_end,
    output logic                   m_run_last
);

    cfg_t cfg;

    esp_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esp_framer u_framer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_packet_end (m_packet_end),
        .m_run_last   (m_run_last)
    );

endmodule

`default_nettype wire

// File: hdl/esp_cfg_regs.sv
// APB register file holding the escape and end codes.
// Depends on esp_pkg.
`default_nettype none

module esp_cfg_regs import esp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.escape_code <= ESCAPE_RESET;
            cfg_reg.end_code    <= END_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_ESCAPE: cfg_reg.escape_code <= pwdata[7:0];
                REG_END:    cfg_reg.end_code    <= pwdata[7:0];
                default:    cfg_reg.end_code    <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ESCAPE: prdata = {24'd0, cfg_reg.escape_code};
            REG_END:    prdata = {24'd0, cfg_reg.end_code};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/esp_framer.sv
// Stuffing and packetizing datapath: input register, pending escaped byte,
// fill counter and output register. Depends on esp_pkg.
`default_nettype none

module esp_framer import esp_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  cfg_t            cfg,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_kind,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_packet_end,
    output logic            m_run_last
);

    logic             in_valid_reg, in_valid_next;
    logic             in_kind_reg;
    logic [7:0]       in_byte_reg;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_end_reg, out_end_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             in_consume;
    logic             emit;
    logic             emit_force;
    logic             needs_escape;
    logic [CNT_W:0]   count_inc;
    logic             closes;

    assign out_free   = !out_valid_reg || m_ready;
    assign in_consume = out_free && !pend_valid_reg && in_valid_reg;
    assign s_ready    = !in_valid_reg || in_consume;

    assign needs_escape = (in_kind_reg == KIND_DATA) &&
                          ((in_byte_reg == cfg.escape_code) ||
                           (in_byte_reg == cfg.end_code));

    // The pending second byte of an escape pair always goes out before the
    // next input word is looked at, so bytes leave in order.
    always_comb begin
        emit            = 1'b0;
        emit_force      = 1'b0;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        if (out_free && pend_valid_reg) begin
            emit            = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end else if (in_consume) begin
            emit = 1'b1;
            if (in_kind_reg == KIND_END) begin
                emit_force    = 1'b1;
                out_byte_next = cfg.end_code;
                out_last_next = 1'b1;
            end else if (needs_escape) begin
                out_byte_next   = cfg.escape_code;
                out_last_next   = 1'b0;
                pend_valid_next = 1'b1;
                pend_byte_next  = in_byte_reg;
            end else begin
                out_byte_next = in_byte_reg;
                out_last_next = 1'b1;
            end
        end
    end

    assign count_inc = {1'b0, fill_reg} + (CNT_W+1)'(1);
    assign closes    = (count_inc >= (CNT_W+1)'(PACKET_BYTES)) || emit_force;

    always_comb begin
        fill_next      = fill_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (emit) begin
            out_valid_next = 1'b1;
            out_end_next   = closes;
            fill_next      = closes ? '0 : count_inc[CNT_W-1:0];
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg && !in_consume;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fill_reg       <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_byte_reg <= s_data_byte;
        end
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_packet_end = out_end_reg;
    assign m_run_last   = out_last_reg;

endmodule

`default_nettype wire
